FILE: src/aff_pkg.sv
// Shared types, constants and mod-26 helpers for the affine character cipher.
// Used by every module of the block; depends on nothing.
package aff_pkg;

	localparam int CHAR_W      = 7;
	localparam int IDX_W       = 5;
	localparam int MKEY_W      = 8;
	localparam int SKEY_W      = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MULT_KEY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHIFT_KEY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd2;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	localparam logic [CHAR_W-1:0] UPPER_A = 7'h41;
	localparam logic [CHAR_W-1:0] UPPER_Z = 7'h5A;
	localparam logic [CHAR_W-1:0] LOWER_A = 7'h61;
	localparam logic [CHAR_W-1:0] LOWER_Z = 7'h7A;

	localparam logic [IDX_W-1:0] ALPHA_LEN   = 5'd26;
	localparam logic [IDX_W-1:0] NO_INV_RES  = 5'd13;
	localparam logic [SKEY_W-1:0] SHIFT_MAX  = 5'd25;

	// x mod 26 for x < 1664: reciprocal estimate, then one correction
	localparam logic [8:0] MOD_RECIP = 9'd315;
	localparam int         MOD_SHIFT = 13;

	typedef struct packed {
		logic [CHAR_W-1:0] chr;
		logic              letter;
		logic              upper;
		logic [IDX_W-1:0]  idx;
	} entry_t;

	typedef struct packed {
		logic              err;
		logic              dir;
		logic [IDX_W-1:0]  a_mod;
		logic [IDX_W-1:0]  a_inv;
		logic [SKEY_W-1:0] shift;
	} key_t;

	function automatic logic [IDX_W-1:0] mod26(input logic [10:0] x);
		logic [19:0] p;
		logic [5:0]  q;
		logic [10:0] r;
		p = 20'(x) * 20'(MOD_RECIP);
		q = p[MOD_SHIFT+5:MOD_SHIFT];
		r = x - 11'(q) * 11'(ALPHA_LEN);
		if (r >= 11'(ALPHA_LEN)) begin
			r = r - 11'(ALPHA_LEN);
		end
		return r[IDX_W-1:0];
	endfunction

	// inverse mod 26 of an odd residue, indexed by residue >> 1
	function automatic logic [IDX_W-1:0] inv26(input logic [3:0] h);
		logic [IDX_W-1:0] v;
		case (h)
			4'd0:    v = 5'd1;
			4'd1:    v = 5'd9;
			4'd2:    v = 5'd21;
			4'd3:    v = 5'd15;
			4'd4:    v = 5'd3;
			4'd5:    v = 5'd19;
			4'd6:    v = 5'd0;
			4'd7:    v = 5'd7;
			4'd8:    v = 5'd23;
			4'd9:    v = 5'd11;
			4'd10:   v = 5'd5;
			4'd11:   v = 5'd17;
			4'd12:   v = 5'd25;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

endpackage

FILE: src/aff_front.sv
// Front end: accepts characters and classifies them (letter, case, index).
// Depends on aff_pkg; feeds aff_queue.
module aff_front (
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [aff_pkg::CHAR_W-1:0] char_in,
	input  logic                      q_full,
	output logic                      q_push,
	output aff_pkg::entry_t           q_entry
);

	logic is_upper;
	logic is_lower;

	assign is_upper = (char_in >= aff_pkg::UPPER_A) && (char_in <= aff_pkg::UPPER_Z);
	assign is_lower = (char_in >= aff_pkg::LOWER_A) && (char_in <= aff_pkg::LOWER_Z);

	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;

	always_comb begin
		q_entry.chr    = char_in;
		q_entry.letter = is_upper || is_lower;
		q_entry.upper  = is_upper;
		if (is_upper) begin
			q_entry.idx = aff_pkg::IDX_W'(char_in - aff_pkg::UPPER_A);
		end else begin
			q_entry.idx = aff_pkg::IDX_W'(char_in - aff_pkg::LOWER_A);
		end
	end

endmodule

FILE: src/aff_queue.sv
// Short queue of classified characters between front and back.
// Depends on aff_pkg for the entry type.
module aff_queue #(
	parameter int DEPTH = aff_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  aff_pkg::entry_t wr_entry,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output aff_pkg::entry_t rd_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	aff_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rd_entry  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: src/aff_back.sv
// Back end: multiply stage, then mod-26 and output register.
// Depends on aff_pkg; drains aff_queue and drives the result channel.
module aff_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  aff_pkg::key_t              key,
	input  logic                       q_not_empty,
	input  aff_pkg::entry_t            q_entry,
	output logic                       q_pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [aff_pkg::CHAR_W-1:0] char_out,
	output logic                       key_error
);

	logic                       valid_s1;
	logic [aff_pkg::CHAR_W-1:0] chr_s1;
	logic                       map_s1;
	logic                       upper_s1;
	logic                       err_s1;
	logic [10:0]                prod_s1;

	logic                       valid_s2;
	logic [aff_pkg::CHAR_W-1:0] chr_s2;
	logic                       err_s2;

	logic                       adv_s2;
	logic                       adv_s1;
	logic [aff_pkg::IDX_W-1:0]  mul_a;
	logic [5:0]                 mul_b;
	logic [aff_pkg::SKEY_W-1:0] add_c;
	logic [aff_pkg::IDX_W-1:0]  res;
	logic [aff_pkg::CHAR_W-1:0] base;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign q_pop  = q_not_empty && adv_s1;

	always_comb begin
		if (key.dir == aff_pkg::DIR_DECRYPT) begin
			mul_a = key.a_inv;
			mul_b = 6'(q_entry.idx) + 6'(aff_pkg::ALPHA_LEN) - 6'(key.shift);
			add_c = '0;
		end else begin
			mul_a = key.a_mod;
			mul_b = 6'(q_entry.idx);
			add_c = key.shift;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			chr_s1   <= q_entry.chr;
			map_s1   <= q_entry.letter && !key.err;
			upper_s1 <= q_entry.upper;
			err_s1   <= key.err;
			prod_s1  <= 11'(mul_a) * 11'(mul_b) + 11'(add_c);
		end
	end

	assign res  = aff_pkg::mod26(prod_s1);
	assign base = upper_s1 ? aff_pkg::UPPER_A : aff_pkg::LOWER_A;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			chr_s2 <= map_s1 ? (base + aff_pkg::CHAR_W'(res)) : chr_s1;
			err_s2 <= err_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_not_empty;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign out_valid = valid_s2;
	assign char_out  = chr_s2;
	assign key_error = err_s2;

endmodule

FILE: src/affine_cipher_char.sv
// Top level of the affine character cipher: key registers, key check, and
// the front / queue / back chain. Depends on aff_pkg, aff_front, aff_queue, aff_back.
//
//   channel   signals                                  handshake
//   input     char_in                                  in_valid / in_ready
//   result    char_out, key_error                      out_valid / out_ready
//   config    cfg_index, cfg_data                      cfg_we (no wait)
//
// One character per cycle sustained while out_ready stays high; each accepted
// character passes queue write, multiply stage, mod-26 into the output register.
// arst_n clears the keys to a=1, b=0, encrypt, and empties the queue and stages.
// A stalled result holds the back stages; the front keeps taking items until
// the queue fills, then drops in_ready.
module affine_cipher_char #(
	parameter int QUEUE_DEPTH = aff_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [aff_pkg::CHAR_W-1:0]     char_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [aff_pkg::CHAR_W-1:0]     char_out,
	output logic                           key_error,
	input  logic                           cfg_we,
	input  logic [aff_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [aff_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [aff_pkg::MKEY_W-1:0] mult_key_q;
	logic [aff_pkg::SKEY_W-1:0] shift_key_q;
	logic                       direction_q;

	aff_pkg::key_t   key;
	aff_pkg::entry_t push_entry;
	aff_pkg::entry_t pop_entry;
	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_not_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_key_q  <= aff_pkg::MKEY_W'(1);
			shift_key_q <= '0;
			direction_q <= aff_pkg::DIR_ENCRYPT;
		end else if (cfg_we) begin
			case (cfg_index)
				aff_pkg::REG_MULT_KEY:  mult_key_q  <= cfg_data[aff_pkg::MKEY_W-1:0];
				aff_pkg::REG_SHIFT_KEY: shift_key_q <= cfg_data[aff_pkg::SKEY_W-1:0];
				aff_pkg::REG_DIRECTION: direction_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		key.a_mod = aff_pkg::mod26(11'(mult_key_q));
		key.a_inv = aff_pkg::inv26(key.a_mod[4:1]);
		key.shift = shift_key_q;
		key.dir   = direction_q;
		key.err   = (mult_key_q == '0) || (shift_key_q > aff_pkg::SHIFT_MAX)
		         || !key.a_mod[0] || (key.a_mod == aff_pkg::NO_INV_RES);
	end

	aff_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.char_in  (char_in),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (push_entry)
	);

	aff_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wr_entry  (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_entry  (pop_entry)
	);

	aff_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.key         (key),
		.q_not_empty (q_not_empty),
		.q_entry     (pop_entry),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_out    (char_out),
		.key_error   (key_error)
	);

endmodule
